// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the blur RTL.
// Each macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define BBR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BBR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/bbr_pkg.sv -----
// Shared types, constants and the 3x3 binomial kernel for the RGB blur.
// No dependencies; used by bbr_outq, binomial_blur_3x3_rgb and the testbench.
package bbr_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int NUM_CH      = 3;
    localparam int PX_W        = SAMPLE_BITS * NUM_CH;
    localparam int SUM_W       = SAMPLE_BITS + 4;
    localparam int CFG_W       = 11;
    localparam int COL_OUT_W   = 10;
    localparam int ROW_OUT_W   = 12;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 72;
    localparam int QDEPTH      = 4;
    localparam int QPW         = $clog2(QDEPTH);
    localparam int QCW         = $clog2(QDEPTH + 1);

    localparam logic [CFG_W-1:0] FW_RESET = 11'd1024;

    // channel 0 is red, in the lowest bits
    typedef logic [NUM_CH-1:0][SAMPLE_BITS-1:0] t_px;

    // one window column: rows above, at and below the center
    typedef struct packed {
        t_px bot;
        t_px mid;
        t_px top;
    } t_col;

    // results caused by one input beat: A is column x-1, B is column x
    typedef struct packed {
        logic                 a_valid;
        logic                 b_valid;
        logic                 done;
        t_px                  pix_a;
        t_px                  pix_b;
        logic [COL_OUT_W-1:0] col_a;
        logic [COL_OUT_W-1:0] col_b;
        logic [ROW_OUT_W-1:0] row;
    } t_pair;

    // weights 1 2 1 / 2 4 2 / 1 2 1, divide by 16, round half up
    function automatic t_px blur_px(input t_col l, input t_col c, input t_col r);
        logic [SUM_W-1:0] corners;
        logic [SUM_W-1:0] edges;
        logic [SUM_W-1:0] sum;
        t_px              res;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            corners = SUM_W'(l.top[ch]) + SUM_W'(r.top[ch])
                    + SUM_W'(l.bot[ch]) + SUM_W'(r.bot[ch]);
            edges   = SUM_W'(c.top[ch]) + SUM_W'(l.mid[ch])
                    + SUM_W'(r.mid[ch]) + SUM_W'(c.bot[ch]);
            sum     = corners + (edges << 1) + (SUM_W'(c.mid[ch]) << 2) + SUM_W'(8);
            res[ch] = sum[SUM_W-1:4];
        end
        return res;
    endfunction

endpackage

// ----- rtl/bbr_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// Read-first on a same-address collision. No dependencies.
module bbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/bbr_outq.sv -----
// Result queue: holds one or two results per input beat and sends them
// out as single beats. Depends on bbr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bbr_outq (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    input  bbr_pkg::t_pair                  i_entry,
    output logic [bbr_pkg::QCW-1:0]         o_count,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [bbr_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    output logic                            o_m_tuser,
    output logic                            o_m_tlast
);

    bbr_pkg::t_pair               r_mem [0:bbr_pkg::QDEPTH-1];
    logic [bbr_pkg::QPW-1:0]      r_wptr;
    logic [bbr_pkg::QPW-1:0]      r_rptr;
    logic [bbr_pkg::QCW-1:0]      r_count;
    logic                         r_second;
    bbr_pkg::t_pair               head;
    logic                         show_b;
    logic                         last_beat;
    logic                         beat;
    logic                         pop;
    bbr_pkg::t_px                 pix;
    logic [bbr_pkg::COL_OUT_W-1:0] col;

    assign head      = r_mem[r_rptr];
    assign show_b    = r_second || !head.a_valid;
    assign last_beat = show_b || !head.b_valid;
    assign beat      = o_m_tvalid && i_m_tready;
    assign pop       = beat && last_beat;

    assign pix = show_b ? head.pix_b : head.pix_a;
    assign col = show_b ? head.col_b : head.col_a;

    assign o_count    = r_count;
    assign o_m_tvalid = (r_count != '0);
    assign o_m_tdata  = {2'b00, head.row, col, pix};
    assign o_m_tlast  = last_beat;
    assign o_m_tuser  = last_beat && head.done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr   <= '0;
            r_rptr   <= '0;
            r_count  <= '0;
            r_second <= 1'b0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + bbr_pkg::QPW'(1);
            end
            if (pop) begin
                r_rptr <= r_rptr + bbr_pkg::QPW'(1);
            end
            if (i_push && !pop) begin
                r_count <= r_count + bbr_pkg::QCW'(1);
            end else if (pop && !i_push) begin
                r_count <= r_count - bbr_pkg::QCW'(1);
            end
            // hold on the second result until its beat goes out
            if (pop) begin
                r_second <= 1'b0;
            end else if (beat) begin
                r_second <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    `BBR_ASSERT_IMP(a_push_room, i_push, r_count != bbr_pkg::QCW'(bbr_pkg::QDEPTH), "result queue overflow")
    `BBR_ASSERT_IMP(a_head_nonempty, o_m_tvalid, head.a_valid || head.b_valid, "queued entry without result")
    `BBR_ASSERT_NXT(a_second_after_first, beat && !last_beat, r_second && o_m_tvalid, "second result lost")

endmodule

// ----- rtl/binomial_blur_3x3_rgb.sv -----
// 3x3 binomial blur of an RGB raster stream: top level with line RAM and window.
// Depends on bbr_pkg, bbr_ram, bbr_outq and assert_macros.svh.
//
// Takes one pixel beat per clock while the result queue has room, and returns
// each channel filtered with 1 2 1 / 2 4 2 / 1 2 1 over 16, rounded half up,
// edges replicated. The two previous rows live in one line RAM (upper and
// middle row side by side), which is read at the pixel's column on the accept
// edge and written back in the cycle after; at frame width 1 the written word
// is forwarded to the next pixel. Each input beat gives at most one output
// beat, except the last column of a row, which gives two if the width is above
// 1; the four-entry result queue lets input keep flowing while the downstream
// stalls, until it fills. Row 0 gives no results; after the last row send
// frame_width beats with tuser set to flush it. The line RAM has no clearing
// pass: what row 0 reads from it feeds no result.
`include "assert_macros.svh"

module binomial_blur_3x3_rgb #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [bbr_pkg::CFG_W-1:0]       i_cfg_wr_data,  // frame_width
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [bbr_pkg::IN_TDATA_W-1:0]  i_s_tdata,      // in_red, in_green, in_blue
    input  logic                            i_s_tuser,      // action
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // out_red, out_green, out_blue, out_col, out_row, 2 zero bits
    output logic [bbr_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    output logic                            o_m_tuser,      // frame_done
    output logic                            o_m_tlast       // run_last
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int EW = (WW > bbr_pkg::CFG_W) ? WW : bbr_pkg::CFG_W;
    localparam int LW = 2 * bbr_pkg::PX_W;
    localparam logic [RW-1:0] ROW_MAX = RW'(MAX_HEIGHT - 1);

    // control
    logic [bbr_pkg::CFG_W-1:0] r_frame_width;
    logic [XW-1:0]             r_col;
    logic [XW-1:0]             n_col;
    logic [RW-1:0]             r_row;
    logic [RW-1:0]             n_row;
    logic                      r_s1_v;
    logic                      r_s2_v;
    logic                      r_fwd;
    logic                      n_fwd;

    // accept-side decode
    logic [EW-1:0]             fw_ext;
    logic [EW-1:0]             w_eff;
    logic [EW-1:0]             w_last;
    logic [EW-1:0]             x_ext;
    logic [XW-1:0]             x;
    logic                      is_end;
    logic                      s_fire;
    logic                      live;
    logic [bbr_pkg::QCW-1:0]   q_count;
    logic [bbr_pkg::QCW-1:0]   occupancy;

    // stage 1: line RAM data arrives
    logic [XW-1:0]             r_s1_x;
    logic                      r_s1_end;
    logic                      r_s1_drain;
    logic                      r_s1_first;
    logic                      r_s1_topmid;
    logic [RW-1:0]             r_s1_row;
    bbr_pkg::t_px              r_s1_cur;
    logic [LW-1:0]             ram_rdata;
    logic [LW-1:0]             r_fwd_data;
    logic [LW-1:0]             line_word;
    logic [LW-1:0]             wr_word;
    bbr_pkg::t_px              up_px;
    bbr_pkg::t_px              mid_px;
    bbr_pkg::t_col             new_col;
    logic                      ram_we;

    // stage 2: window complete, filter
    logic [XW-1:0]             r_s2_x;
    logic                      r_s2_end;
    logic                      r_s2_drain;
    logic                      r_s2_first;
    logic [RW-1:0]             r_s2_row;
    bbr_pkg::t_col             r_win0;
    bbr_pkg::t_col             r_win1;
    bbr_pkg::t_col             r_win2;
    bbr_pkg::t_col             lc_a;
    bbr_pkg::t_col             lc_b;
    bbr_pkg::t_pair            entry;
    logic                      s2_push;

    // clamp the configured width to 1..MAX_WIDTH, and the column to the width
    always_comb begin
        fw_ext = EW'(r_frame_width);
        if (fw_ext == '0) begin
            w_eff = EW'(1);
        end else if (fw_ext > EW'(MAX_WIDTH)) begin
            w_eff = EW'(MAX_WIDTH);
        end else begin
            w_eff = fw_ext;
        end
        w_last = w_eff - EW'(1);
        x_ext  = (EW'(r_col) > w_last) ? w_last : EW'(r_col);
        x      = x_ext[XW-1:0];
        is_end = (x_ext == w_last);
    end

    assign occupancy  = q_count + bbr_pkg::QCW'(r_s1_v) + bbr_pkg::QCW'(r_s2_v);
    assign o_s_tready = (occupancy < bbr_pkg::QCW'(bbr_pkg::QDEPTH));
    assign s_fire     = i_s_tvalid && o_s_tready;
    // drop a drain beat that arrives in row 0: no state change
    assign live       = s_fire && !(i_s_tuser && (r_row == '0));

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (live) begin
            if (is_end) begin
                n_col = '0;
                if (i_s_tuser) begin
                    n_row = '0;
                end else if (r_row != ROW_MAX) begin
                    n_row = r_row + RW'(1);
                end
            end else begin
                n_col = x + XW'(1);
            end
        end
    end

    // the same entry is read on the edge it is written only at width 1
    assign ram_we = r_s1_v && !r_s1_drain;
    assign n_fwd  = live && ram_we && (r_s1_x == x);

    assign line_word = r_fwd ? r_fwd_data : ram_rdata;
    assign mid_px    = line_word[bbr_pkg::PX_W-1:0];
    assign up_px     = line_word[LW-1:bbr_pkg::PX_W];
    assign wr_word   = {mid_px, r_s1_cur};

    always_comb begin
        new_col.top = r_s1_topmid ? mid_px : up_px;
        new_col.mid = mid_px;
        new_col.bot = r_s1_drain ? mid_px : r_s1_cur;
    end

    bbr_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_WIDTH)
    ) u_lines (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_s1_x),
        .i_wdata (wr_word),
        .i_re    (live),
        .i_raddr (x),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width <= bbr_pkg::FW_RESET;
            r_col         <= '0;
            r_row         <= '0;
            r_s1_v        <= 1'b0;
            r_s2_v        <= 1'b0;
            r_fwd         <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_frame_width <= i_cfg_wr_data;
            end
            r_col  <= n_col;
            r_row  <= n_row;
            r_s1_v <= live;
            r_s2_v <= r_s1_v;
            r_fwd  <= n_fwd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (live) begin
            r_s1_x      <= x;
            r_s1_end    <= is_end;
            r_s1_drain  <= i_s_tuser;
            r_s1_first  <= (r_row == '0);
            r_s1_topmid <= (r_row <= RW'(1));
            r_s1_row    <= r_row;
            r_s1_cur    <= i_s_tdata;
        end
        r_fwd_data <= wr_word;
        // shift the window left and load the new column
        if (r_s1_v) begin
            r_win0     <= r_win1;
            r_win1     <= r_win2;
            r_win2     <= new_col;
            r_s2_x     <= r_s1_x;
            r_s2_end   <= r_s1_end;
            r_s2_drain <= r_s1_drain;
            r_s2_first <= r_s1_first;
            r_s2_row   <= r_s1_row;
        end
    end

    // A is column x-1, B the right edge column x at the row end
    assign lc_a = (r_s2_x == XW'(1)) ? r_win1 : r_win0;
    assign lc_b = (r_s2_x == '0) ? r_win2 : r_win1;

    always_comb begin
        entry.a_valid = (r_s2_x != '0);
        entry.b_valid = r_s2_end;
        entry.done    = r_s2_drain && r_s2_end;
        entry.pix_a   = bbr_pkg::blur_px(lc_a, r_win1, r_win2);
        entry.pix_b   = bbr_pkg::blur_px(lc_b, r_win2, r_win2);
        entry.col_a   = bbr_pkg::COL_OUT_W'(r_s2_x - XW'(1));
        entry.col_b   = bbr_pkg::COL_OUT_W'(r_s2_x);
        entry.row     = bbr_pkg::ROW_OUT_W'(r_s2_row - RW'(1));
    end

    assign s2_push = r_s2_v && !r_s2_first && (entry.a_valid || entry.b_valid);

    bbr_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (s2_push),
        .i_entry    (entry),
        .o_count    (q_count),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    `BBR_ASSERT_IMP(a_fwd_live, r_fwd, r_s1_v, "line forward without a stage-1 pixel")
    `BBR_ASSERT_IMP(a_row_bound, 1'b1, r_row <= ROW_MAX, "row counter past maximum height")
    `BBR_ASSERT_NXT(a_s2_follows, r_s1_v, r_s2_v, "stage-1 pixel did not reach the filter")

endmodule

// ----- tb/binomial_blur_3x3_rgb_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for binomial_blur_3x3_rgb: streams pixel and drain beats,
// predicts every blurred output beat and checks them in order. Depends on bbr_pkg.
module binomial_blur_3x3_rgb_tb;
    import bbr_pkg::*;

    localparam int   LINE_MAX      = 1024;
    localparam int   ROW_MAX       = 4096;
    localparam int   CYCLE_LIMIT   = 900_000;
    localparam int   SETTLE_CYCLES = 12;
    localparam int   LONG_HOLD     = 300;
    localparam int   RANDOM_ITEMS  = 1150;
    localparam logic ACT_PIXEL     = 1'b0;
    localparam logic ACT_DRAIN     = 1'b1;

    typedef enum {SINK_OPEN, SINK_RANDOM, SINK_PATTERN} sink_mode_e;

    typedef struct {
        logic [SAMPLE_BITS-1:0] red;
        logic [SAMPLE_BITS-1:0] green;
        logic [SAMPLE_BITS-1:0] blue;
        logic [COL_OUT_W-1:0]   col;
        logic [ROW_OUT_W-1:0]   row;
        logic                   run_last;
        logic                   frame_done;
    } blurred_px_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_W-1:0]       cfg_wr_data = '0;
    logic                   s_tvalid = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tready = 1'b0;
    logic                   s_tready;
    logic                   m_tvalid;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;
    logic                   m_tlast;

    binomial_blur_3x3_rgb dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_s_tvalid    (s_tvalid),
        .o_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .o_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .o_m_tdata     (m_tdata),
        .o_m_tuser     (m_tuser),
        .o_m_tlast     (m_tlast)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // blur predictor state
    logic [CFG_W-1:0] width_reg;
    t_px              upper_row [LINE_MAX];
    t_px              middle_row [LINE_MAX];
    bit               upper_ok [LINE_MAX];
    bit               middle_ok [LINE_MAX];
    t_px              win_col [3][3];  // [column][row], column 2 is the newest
    int unsigned      col_pos;
    int unsigned      row_pos;
    blurred_px_t      blurred_q [$];

    // traffic control and bookkeeping
    int          gap_max = 0;
    int          burst_left = 0;
    sink_mode_e  sink_mode = SINK_OPEN;
    logic [15:0] sink_pattern = 16'hffff;
    int          sink_cycle = 0;
    int          hold_left = 0;
    int          cycle_count = 0;
    int          mismatch_count = 0;
    int          items_sent = 0;
    int          results_seen = 0;
    int          cfg_writes = 0;

    function automatic void blur_reset();
        width_reg = FW_RESET;
        for (int i = 0; i < LINE_MAX; i++) begin
            upper_row[i]  = '0;
            middle_row[i] = '0;
            upper_ok[i]   = 1'b0;
            middle_ok[i]  = 1'b0;
        end
        for (int c = 0; c < 3; c++)
            for (int r = 0; r < 3; r++)
                win_col[c][r] = '0;
        col_pos = 0;
        row_pos = 0;
    endfunction

    function automatic int unsigned eff_width();
        if (width_reg == 0)
            return 1;
        if (width_reg > LINE_MAX)
            return LINE_MAX;
        return width_reg;
    endfunction

    function automatic int unsigned cur_col();
        int unsigned w;
        w = eff_width();
        return (col_pos >= w) ? w - 1 : col_pos;
    endfunction

    // A drain mid-row leaves the line entry as it was; keep it off columns whose
    // upper entry still holds a row that never went through the window.
    function automatic bit drain_is_safe();
        int unsigned x;
        x = cur_col();
        return row_pos == 0 || x == eff_width() - 1 || upper_ok[x];
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] kernel_sum(int lc, int cc, int rc, int ch);
        int unsigned acc;
        acc = win_col[lc][0][ch] + win_col[rc][0][ch] + win_col[lc][2][ch]
            + win_col[rc][2][ch]
            + 2 * (win_col[cc][0][ch] + win_col[lc][1][ch] + win_col[rc][1][ch]
                   + win_col[cc][2][ch])
            + 4 * win_col[cc][1][ch] + 8;
        return SAMPLE_BITS'(acc >> 4);
    endfunction

    function automatic blurred_px_t blur_at(int lc, int cc, int rc, int unsigned col);
        blurred_px_t b;
        b.red        = kernel_sum(lc, cc, rc, 0);
        b.green      = kernel_sum(lc, cc, rc, 1);
        b.blue       = kernel_sum(lc, cc, rc, 2);
        b.col        = COL_OUT_W'(col);
        b.row        = ROW_OUT_W'(row_pos - 1);
        b.run_last   = 1'b0;
        b.frame_done = 1'b0;
        return b;
    endfunction

    // Advance the predictor by one accepted beat and queue the pixels it yields.
    function automatic void advance_blur(input logic act, input t_px px);
        int unsigned w;
        int unsigned x;
        bit          drain;
        bit          row_end;
        t_px         mid;
        blurred_px_t res [2];
        int          n;
        w       = eff_width();
        x       = cur_col();
        drain   = (act == ACT_DRAIN);
        row_end = (x == w - 1);
        n       = 0;
        if (drain && row_pos == 0)
            return;
        for (int r = 0; r < 3; r++) begin
            win_col[0][r] = win_col[1][r];
            win_col[1][r] = win_col[2][r];
        end
        mid = middle_row[x];
        win_col[2][0] = (row_pos <= 1) ? mid : upper_row[x];
        win_col[2][1] = mid;
        win_col[2][2] = drain ? mid : px;
        if (!drain) begin
            upper_row[x]  = mid;
            middle_row[x] = px;
            upper_ok[x]   = middle_ok[x];
            middle_ok[x]  = 1'b1;
        end
        if (row_pos > 0) begin
            if (x >= 1) begin
                res[n] = blur_at((x == 1) ? 1 : 0, 1, 2, x - 1);
                n++;
            end
            if (row_end) begin
                res[n] = blur_at((x == 0) ? 2 : 1, 2, 2, x);
                n++;
            end
            if (n > 0) begin
                res[n-1].run_last   = 1'b1;
                res[n-1].frame_done = drain && row_end;
            end
            for (int i = 0; i < n; i++)
                blurred_q.push_back(res[i]);
        end
        if (row_end) begin
            col_pos = 0;
            if (drain)
                row_pos = 0;
            else if (row_pos < ROW_MAX - 1)
                row_pos++;
        end else begin
            col_pos = x + 1;
        end
    endfunction

    function automatic t_px rand_px();
        t_px p;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            case ($urandom_range(0, 5))
                0: p[ch] = '0;
                1: p[ch] = '1;
                2: p[ch] = SAMPLE_BITS'($urandom_range(0, 15));
                default: p[ch] = SAMPLE_BITS'($urandom);
            endcase
        end
        return p;
    endfunction

    // Offer one beat; called and returning at a rising edge.
    task automatic send_item(input logic act, input t_px px);
        logic go;
        if (act == ACT_DRAIN && !drain_is_safe())
            act = ACT_PIXEL;
        if (gap_max > 0 && burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, gap_max)) @(posedge clk);
            burst_left = $urandom_range(1, 16);
        end
        if (burst_left > 0)
            burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= px;
        do begin
            @(negedge clk);
            go = s_tready;
            if (go)
                advance_blur(act, px);
            @(posedge clk);
        end while (!go);
        items_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (blurred_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_width(input logic [CFG_W-1:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        width_reg = val;
        cfg_writes++;
    endtask

    // Finish the current frame: complete row 0 with pixels, then drain.
    task automatic close_frame();
        while (row_pos != 0 || col_pos != 0)
            send_item((row_pos == 0) ? ACT_PIXEL : ACT_DRAIN, rand_px());
    endtask

    task automatic send_frame(input int rows, input int noise_pct, input bit drop_width);
        int total;
        total = rows * eff_width();
        for (int i = 0; i < total; i++) begin
            if (drop_width && i == total / 2 && row_pos > 0) begin
                wait_drained();
                write_width(CFG_W'($urandom_range(1, eff_width())));
            end
            send_item(($urandom_range(0, 99) < noise_pct) ? ACT_DRAIN : ACT_PIXEL, rand_px());
        end
        close_frame();
    endtask

    function automatic void check_field(input string what, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $display("%0t ns: %s expected %h actual %h", $time, what, want, got);
            mismatch_count++;
        end
    endfunction

    // output side: open, random or pattern stalls, long hold-off
    always @(posedge clk) begin
        sink_cycle <= sink_cycle + 1;
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            case (sink_mode)
                SINK_OPEN:   m_tready <= 1'b1;
                SINK_RANDOM: m_tready <= ($urandom_range(0, 99) < 65);
                default:     m_tready <= sink_pattern[sink_cycle % 16];
            endcase
        end
    end

    // check each output beat; values are stable between the falling and rising edge
    always @(negedge clk) begin : check_beat
        blurred_px_t want;
        if (rst_n && m_tvalid && m_tready) begin
            results_seen++;
            if (blurred_q.size() == 0) begin
                $display("%0t ns: unexpected output beat, expected none actual %h",
                         $time, m_tdata);
                mismatch_count++;
            end else begin
                want = blurred_q.pop_front();
                check_field("out_red", want.red, m_tdata[15:0]);
                check_field("out_green", want.green, m_tdata[31:16]);
                check_field("out_blue", want.blue, m_tdata[47:32]);
                check_field("out_col", 16'(want.col), 16'(m_tdata[57:48]));
                check_field("out_row", 16'(want.row), 16'(m_tdata[69:58]));
                check_field("pad bits", 16'h0, 16'(m_tdata[71:70]));
                check_field("run_last", 16'(want.run_last), 16'(m_tlast));
                check_field("frame_done", 16'(want.frame_done), 16'(m_tuser));
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, blurred_q.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic test_drain_before_first_row();
        gap_max   = 0;
        sink_mode = SINK_OPEN;
        send_item(ACT_DRAIN, '1);
        send_item(ACT_DRAIN, rand_px());
        wait_drained();
    endtask

    // full frame at the reset width, no register write before it
    task automatic test_reset_width_frame();
        gap_max   = 2;
        sink_mode = SINK_RANDOM;
        send_frame(1, 0, 1'b0);
        wait_drained();
    endtask

    task automatic test_small_frame_extremes();
        write_width(CFG_W'(3));
        send_item(ACT_PIXEL, '1);
        send_item(ACT_DRAIN, '0);  // row 0 drain: dropped
        send_item(ACT_PIXEL, '1);
        send_item(ACT_PIXEL, '1);
        repeat (3) send_item(ACT_PIXEL, '1);
        send_item(ACT_PIXEL, '0);
        send_item(ACT_PIXEL, t_px'({16'h7fff, 16'h0008, 16'h0001}));
        send_item(ACT_PIXEL, '1);
        close_frame();
        wait_drained();
    endtask

    task automatic test_single_column();
        write_width(CFG_W'(0));
        send_item(ACT_PIXEL, '1);
        send_item(ACT_PIXEL, '0);
        send_item(ACT_PIXEL, rand_px());
        close_frame();
        wait_drained();
    endtask

    task automatic test_width_lowered_mid_row();
        gap_max = 3;
        write_width(CFG_W'(6));
        repeat (10) send_item(ACT_PIXEL, rand_px());
        wait_drained();
        write_width(CFG_W'(2));
        repeat (3) send_item(ACT_PIXEL, rand_px());
        close_frame();
        wait_drained();
    endtask

    task automatic test_mixed_actions();
        write_width(CFG_W'(4));
        repeat (6) send_item(ACT_PIXEL, rand_px());
        send_item(ACT_DRAIN, rand_px());
        send_item(ACT_DRAIN, rand_px());  // drain at row end closes the frame
        repeat (8) send_item(ACT_PIXEL, rand_px());
        send_item(ACT_DRAIN, rand_px());
        send_item(ACT_PIXEL, rand_px());  // pixel during drain advances the row
        send_item(ACT_DRAIN, rand_px());
        send_item(ACT_DRAIN, rand_px());
        close_frame();
        wait_drained();
    endtask

    task automatic test_width_clamp();
        write_width(CFG_W'(2047));
        send_frame(1, 0, 1'b0);
        wait_drained();
    endtask

    task automatic test_row_saturation();
        gap_max   = 0;
        sink_mode = SINK_OPEN;
        write_width(CFG_W'(1));
        repeat (ROW_MAX + 3) send_item(ACT_PIXEL, rand_px());
        close_frame();
        wait_drained();
    endtask

    // hold the output side off while input keeps coming; the block must stall its input
    task automatic test_output_stall();
        gap_max      = 0;
        sink_mode    = SINK_PATTERN;
        sink_pattern = 16'($urandom) | 16'h0101;
        write_width(CFG_W'(8));
        hold_left = LONG_HOLD;
        send_frame(3, 0, 1'b0);
        wait_drained();
    endtask

    task automatic test_random_frames();
        int start;
        int w;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       w = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 2);
                1, 2:    w = $urandom_range(9, 40);
                default: w = $urandom_range(1, 8);
            endcase
            case ($urandom_range(0, 3))
                0:       gap_max = 0;
                1:       gap_max = 2;
                default: gap_max = 6;
            endcase
            sink_mode    = sink_mode_e'($urandom_range(0, 2));
            sink_pattern = 16'($urandom) | 16'h0101;
            wait_drained();
            write_width(CFG_W'(w));
            send_frame($urandom_range(1, 6),
                       ($urandom_range(0, 9) < 6) ? 0 : $urandom_range(5, 25),
                       $urandom_range(0, 99) < 15);
        end
        wait_drained();
    endtask

    initial begin
        blur_reset();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_drain_before_first_row();
        test_reset_width_frame();
        test_small_frame_extremes();
        test_single_column();
        test_width_lowered_mid_row();
        test_mixed_actions();
        test_width_clamp();
        test_row_saturation();
        test_output_stall();
        test_random_frames();
        wait_drained();
        mismatch_count += blurred_q.size();
        $display("covered: %0d input beats, %0d output beats, %0d width writes",
                 items_sent, results_seen, cfg_writes);
        $display("widths 0 to 2047, row counter saturation, long output hold-off");
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/bbr_pkg.sv
rtl/bbr_ram.sv
rtl/bbr_outq.sv
rtl/binomial_blur_3x3_rgb.sv
tb/binomial_blur_3x3_rgb_tb.sv
